FILE: rtl/core/lprc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizes for the pointer region check block.
package lprc_pkg;

	localparam int MAX_REGIONS = 64;
	localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
	localparam int ENT_W       = 7;
	localparam int ST_W        = 3;
	localparam int ACT_W       = 2;
	localparam int DATA_W      = 64;

	localparam logic [ACT_W-1:0] ACT_CLEAR    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_INSERT   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLASSIFY = 2'd2;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_NULL     = 3'd1;
	localparam logic [ST_W-1:0] ST_ODD      = 3'd2;
	localparam logic [ST_W-1:0] ST_NONCANON = 3'd3;
	localparam logic [ST_W-1:0] ST_OUTSIDE  = 3'd4;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd5;

	localparam logic [DATA_W-1:0] ALIGN_MASK = 64'h0000_0000_0000_0001;
	localparam logic [DATA_W-1:0] HIGH_MASK  = 64'hffff_0000_0000_0000;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] region_start;
		logic [DATA_W-1:0] region_end;
	} in_t;

	typedef struct packed {
		logic             is_pointer;
		logic [ST_W-1:0]  status;
		logic [ENT_W-1:0] entries_used;
	} out_t;

	typedef struct packed {
		logic [DATA_W-1:0] lo_addr;
		logic [DATA_W-1:0] hi_addr;
	} region_t;

	typedef struct packed {
		logic            load;
		logic            clr_cnt;
		logic            srch_init;
		logic            srch_step;
		logic            sh_init;
		logic            sh_rd;
		logic            sh_wr;
		logic            ins_wr;
		logic            finish;
		logic            fin_hit;
		logic [ST_W-1:0] fin_status;
	} cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic             full;
		logic             val_zero;
		logic             val_odd;
		logic             val_noncanon;
		logic             lo_lt_hi;
		logic             ptr_gt_pos;
		logic             in_range;
	} sts_t;

endpackage

FILE: rtl/core/lprc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module lprc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: rtl/core/lprc_dp.sv
`timescale 1ns / 1ps
// Datapath: region table RAM, search bounds, shift pointer, count and result register.
module lprc_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  lprc_pkg::in_t item,
	input  lprc_pkg::cmd_t cmd,
	output lprc_pkg::sts_t sts,
	output lprc_pkg::out_t result,
	output logic          done
);
	import lprc_pkg::*;

	logic [ACT_W-1:0]  act_q;
	logic [DATA_W-1:0] key_q;
	logic [DATA_W-1:0] rend_q;
	logic [DATA_W-1:0] endc_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hi_q;
	logic [CNT_W-1:0]  ptr_q;
	logic              found_q;
	out_t              result_q;
	logic              done_q;

	logic [CNT_W-1:0]  mid;
	logic [CNT_W-1:0]  ptr_m1;
	logic [DATA_W-1:0] key_high;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [IDX_W-1:0]  raddr;
	region_t           wdata;
	region_t           rdata;

	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign ptr_m1   = ptr_q - CNT_W'(1);
	assign key_high = key_q & HIGH_MASK;

	// Shift moves entry ptr-1 up to ptr; the final write places the new region at lo.
	assign we    = cmd.sh_wr | cmd.ins_wr;
	assign waddr = cmd.sh_wr ? ptr_q[IDX_W-1:0] : lo_q[IDX_W-1:0];
	assign wdata = cmd.sh_wr ? rdata : region_t'({key_q, rend_q});
	assign raddr = cmd.sh_rd ? ptr_m1[IDX_W-1:0] : mid[IDX_W-1:0];

	lprc_ram #(
		.WIDTH($bits(region_t)),
		.DEPTH(MAX_REGIONS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= item.action;
			key_q  <= (item.action == ACT_INSERT) ? item.region_start : item.value;
			rend_q <= item.region_end;
		end
		if (cmd.srch_step && !(key_q < rdata.lo_addr)) begin
			endc_q <= rdata.hi_addr;
		end
		if (cmd.finish) begin
			result_q.is_pointer   <= cmd.fin_hit;
			result_q.status       <= cmd.fin_status;
			result_q.entries_used <= ENT_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			ptr_q   <= '0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.clr_cnt) begin
				count_q <= '0;
			end else if (cmd.ins_wr) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.srch_init) begin
				lo_q    <= '0;
				hi_q    <= count_q;
				found_q <= 1'b0;
			end else if (cmd.srch_step) begin
				if (key_q < rdata.lo_addr) begin
					hi_q <= mid;
				end else begin
					// last entry not above the key so far: remember its end
					lo_q    <= mid + CNT_W'(1);
					found_q <= 1'b1;
				end
			end
			if (cmd.sh_init) begin
				ptr_q <= count_q;
			end else if (cmd.sh_wr) begin
				ptr_q <= ptr_m1;
			end
		end
	end

	assign sts.action       = act_q;
	assign sts.full         = (count_q >= CNT_W'(MAX_REGIONS));
	assign sts.val_zero     = (key_q == '0);
	assign sts.val_odd      = ((key_q & ALIGN_MASK) != '0);
	assign sts.val_noncanon = (key_high != '0) && (key_high != HIGH_MASK);
	assign sts.lo_lt_hi     = (lo_q < hi_q);
	assign sts.ptr_gt_pos   = (ptr_q > lo_q);
	assign sts.in_range     = found_q && (key_q < endc_q);

	assign result = result_q;
	assign done   = done_q;
endmodule

FILE: rtl/core/lprc_ctl.sv
`timescale 1ns / 1ps
// Controller: sequences decode, binary search, entry shift, insert and result.
module lprc_ctl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  lprc_pkg::sts_t sts,
	output lprc_pkg::cmd_t cmd
);
	import lprc_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DECODE   = 3'd1;
	localparam logic [2:0] S_SRCH_RD  = 3'd2;
	localparam logic [2:0] S_SRCH_CMP = 3'd3;
	localparam logic [2:0] S_SH_RD    = 3'd4;
	localparam logic [2:0] S_SH_WR    = 3'd5;
	localparam logic [2:0] S_INS_WR   = 3'd6;
	localparam logic [2:0] S_FIN      = 3'd7;

	logic [2:0]      state_q;
	logic [2:0]      state_d;
	logic [ST_W-1:0] stat_q;
	logic [ST_W-1:0] stat_d;
	logic            hit_q;
	logic            hit_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		stat_d  = stat_q;
		hit_d   = hit_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				hit_d  = 1'b0;
				stat_d = ST_OK;
				state_d = S_FIN;
				case (sts.action)
					ACT_CLEAR: begin
						cmd.clr_cnt = 1'b1;
					end
					ACT_INSERT: begin
						if (sts.full) begin
							stat_d = ST_FULL;
						end else begin
							cmd.srch_init = 1'b1;
							state_d       = S_SRCH_RD;
						end
					end
					ACT_CLASSIFY: begin
						if (sts.val_zero) begin
							stat_d = ST_NULL;
						end else if (sts.val_odd) begin
							stat_d = ST_ODD;
						end else if (sts.val_noncanon) begin
							stat_d = ST_NONCANON;
						end else begin
							cmd.srch_init = 1'b1;
							state_d       = S_SRCH_RD;
						end
					end
					default: begin
						stat_d = ST_OK;
					end
				endcase
			end
			S_SRCH_RD: begin
				if (sts.lo_lt_hi) begin
					state_d = S_SRCH_CMP;
				end else if (sts.action == ACT_CLASSIFY) begin
					hit_d   = sts.in_range;
					stat_d  = sts.in_range ? ST_OK : ST_OUTSIDE;
					state_d = S_FIN;
				end else begin
					cmd.sh_init = 1'b1;
					state_d     = S_SH_RD;
				end
			end
			S_SRCH_CMP: begin
				cmd.srch_step = 1'b1;
				state_d       = S_SRCH_RD;
			end
			S_SH_RD: begin
				if (sts.ptr_gt_pos) begin
					cmd.sh_rd = 1'b1;
					state_d   = S_SH_WR;
				end else begin
					state_d = S_INS_WR;
				end
			end
			S_SH_WR: begin
				cmd.sh_wr = 1'b1;
				state_d   = S_SH_RD;
			end
			S_INS_WR: begin
				cmd.ins_wr = 1'b1;
				stat_d     = ST_OK;
				state_d    = S_FIN;
			end
			S_FIN: begin
				cmd.finish     = 1'b1;
				cmd.fin_hit    = hit_q;
				cmd.fin_status = stat_q;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stat_q  <= ST_OK;
			hit_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			stat_q  <= stat_d;
			hit_q   <= hit_d;
		end
	end

	assign busy = (state_q != S_IDLE);
endmodule

FILE: rtl/core/likely_pointer_region_check.sv
`timescale 1ns / 1ps
// Top level: region table with sorted insert and likely-pointer classification.
//
// Usage: drive item (action, value, region_start, region_end) and raise start;
// the item is taken at a rising edge with start high and busy low. busy then
// stays high until the item is finished. Each item gives one result on result,
// valid for exactly one cycle while done is high; the receiver cannot stall,
// so it must capture result in that cycle. A new item may be started in the
// cycle that done is high.
// Sequence of an item after the accepting edge:
//   clear, unused code, rejected value, full table: decode, then result.
//   classify: decode, binary search of about log2(entries)+1 steps, result.
//   insert: decode, search, move each entry above the place up, write, result.
// Each search step and each moved entry waits on the registered read of the
// single table RAM (one read and one write port).
// Reset clears the entry count and the control state; table contents are
// not cleared, since only entries below the count are ever read.
module likely_pointer_region_check (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  lprc_pkg::in_t  item,
	output logic           done,
	output lprc_pkg::out_t result
);
	import lprc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lprc_ctl u_ctl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.sts   (sts),
		.cmd   (cmd)
	);

	lprc_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.cmd   (cmd),
		.sts   (sts),
		.result(result),
		.done  (done)
	);
endmodule

FILE: rtl/core/lprc_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the pointer region check block, bound to the top level.
module lprc_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input lprc_pkg::in_t  item,
	input logic           done,
	input lprc_pkg::out_t result
);
	import lprc_pkg::*;

	// an accepted item raises busy to hold off new items, with done still low
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted item did not raise busy or finished too early");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("one item gave more than one result");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status <= ST_FULL))
		else $error("undefined status code");

	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.is_pointer) |-> (result.status == ST_OK))
		else $error("pointer hit with non-ok status");
endmodule

bind likely_pointer_region_check lprc_chk u_lprc_chk (.*);
